/* rtl/core/hss_pkg.sv */
// shared types, codes and pattern tables of the hall six-step commutator
package hss_pkg;

    localparam logic [1:0] CMD_HALL       = 2'd0;
    localparam logic [1:0] CMD_TICK       = 2'd1;
    localparam logic [1:0] CMD_CHOP_SHORT = 2'd2;
    localparam logic [1:0] CMD_CHOP_POWER = 2'd3;

    localparam logic [1:0] MODE_TIMED      = 2'd0;
    localparam logic [1:0] MODE_TIMED_HALL = 2'd1;
    localparam logic [1:0] MODE_HALL_ONLY  = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_ADVANCE   = 2'd2;
    localparam logic [1:0] REG_MODE      = 2'd3;

    localparam logic [9:0]  THRESHOLD_RESET = 10'd512;
    localparam logic [2:0]  OFFSET_RESET    = 3'd0;
    localparam logic [2:0]  ADVANCE_RESET   = 3'd2;
    localparam logic [1:0]  MODE_RESET      = MODE_TIMED_HALL;
    localparam logic [13:0] POS_LIMIT       = 14'd10000;
    localparam logic [7:0]  ALL_OFF         = 8'h1C;

    typedef struct packed {
        logic [9:0] threshold;
        logic [2:0] offset;
        logic [2:0] advance;
        logic [1:0] mode;
    } t_cfg;

    // classified item: command, per-hall on/off flags (bit 0 a, 1 b, 2 c), run
    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] hall_on;
        logic [2:0] hall_off;
        logic       run;
    } t_cls;

    typedef struct packed {
        logic [7:0]  gate_pattern;
        logic [2:0]  drive_step;
        logic [2:0]  sector;
        logic [13:0] position_count;
    } t_res;

    typedef struct packed {
        logic in_empty;
        logic out_full;
    } t_back_stat;

    typedef struct packed {
        logic in_pop;
        logic out_push;
    } t_back_ctl;

    // (x - 1) mod 6 + 1 for x in -5..16
    function automatic logic [2:0] wrap6(input logic signed [5:0] x);
        logic [5:0] y;
        logic [5:0] t;
        y = 6'(x + 6'sd23);
        t = y - 6'd18;
        if (t >= 6'd18) begin
            t = t - 6'd18;
        end
        if (t >= 6'd12) begin
            t = t - 6'd12;
        end
        if (t >= 6'd6) begin
            t = t - 6'd6;
        end
        return 3'(t + 6'd1);
    endfunction

    function automatic logic [7:0] powered_pattern(input logic [2:0] step);
        logic [7:0] p;
        unique case (step)
            3'd1: p = 8'h98;
            3'd2: p = 8'h94;
            3'd3: p = 8'h34;
            3'd4: p = 8'h2C;
            3'd5: p = 8'h4C;
            3'd6: p = 8'h58;
            default: p = ALL_OFF;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] shorted_pattern(input logic [2:0] step);
        logic [7:0] p;
        unique case (step)
            3'd1, 3'd4: p = 8'hBC;
            3'd2, 3'd5: p = 8'hDC;
            3'd3, 3'd6: p = 8'h7C;
            default: p = ALL_OFF;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/hall_six_step_commutator.sv */
// top level of the hall six-step commutator
// Takes one item per clock cycle on the push side while the input queue is not full and
// returns one result per item, in order. An accepted item is classified against the hall
// threshold into a two-entry queue; the back part updates sector, position count and
// commutation step and writes the result into a two-entry output queue, which registers it
// before it is on the result ports. The sustained rate of one item per cycle, while the
// output queue is not full, is set by the state update loop of the back part. Configuration
// writes take effect at once and are meant to be made only while no item is in flight.
module hall_six_step_commutator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_hall_a,
    input  logic [9:0]  i_hall_b,
    input  logic [9:0]  i_hall_c,
    input  logic        i_run,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_gate_pattern,
    output logic [2:0]  o_drive_step,
    output logic [2:0]  o_sector,
    output logic [13:0] o_position_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import hss_pkg::*;

    t_cfg       r_cfg;
    t_cls       front_cls;
    t_cls       queue_cls;
    t_res       back_res;
    t_res       out_res;
    t_back_stat back_stat;
    t_back_ctl  back_ctl;
    logic       front_push;
    logic       cls_full;
    logic       cls_empty;
    logic       res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RESET;
            r_cfg.offset    <= OFFSET_RESET;
            r_cfg.advance   <= ADVANCE_RESET;
            r_cfg.mode      <= MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                REG_OFFSET:    r_cfg.offset    <= i_cfg_data[2:0];
                REG_ADVANCE:   r_cfg.advance   <= i_cfg_data[2:0];
                REG_MODE:      r_cfg.mode      <= i_cfg_data[1:0];
            endcase
        end
    end

    hss_front u_front (
        .i_push       (push),
        .i_queue_full (cls_full),
        .i_command    (i_command),
        .i_hall_a     (i_hall_a),
        .i_hall_b     (i_hall_b),
        .i_hall_c     (i_hall_c),
        .i_run        (i_run),
        .i_threshold  (r_cfg.threshold),
        .o_queue_push (front_push),
        .o_cls        (front_cls)
    );

    hss_queue #(.WIDTH($bits(t_cls))) u_cls_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cls),
        .o_full  (cls_full),
        .i_pop   (back_ctl.in_pop),
        .o_empty (cls_empty),
        .o_data  (queue_cls)
    );

    assign back_stat.in_empty = cls_empty;
    assign back_stat.out_full = res_full;

    hss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cls   (queue_cls),
        .i_stat  (back_stat),
        .o_ctl   (back_ctl),
        .o_res   (back_res)
    );

    hss_queue #(.WIDTH($bits(t_res))) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_ctl.out_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign full             = cls_full;
    assign o_gate_pattern   = out_res.gate_pattern;
    assign o_drive_step     = out_res.drive_step;
    assign o_sector         = out_res.sector;
    assign o_position_count = out_res.position_count;

endmodule

/* rtl/core/hss_queue.sv */
// two-entry queue with simultaneous push and pop
module hss_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/hss_front.sv */
// front part: accepts items and classifies the hall readings against the threshold
module hss_front (
    input  logic         i_push,
    input  logic         i_queue_full,
    input  logic [1:0]   i_command,
    input  logic [9:0]   i_hall_a,
    input  logic [9:0]   i_hall_b,
    input  logic [9:0]   i_hall_c,
    input  logic         i_run,
    input  logic [9:0]   i_threshold,
    output logic         o_queue_push,
    output hss_pkg::t_cls o_cls
);
    import hss_pkg::*;

    assign o_queue_push = i_push && !i_queue_full;

    always_comb begin
        o_cls.cmd         = i_command;
        o_cls.run         = i_run;
        o_cls.hall_on[0]  = i_hall_a < i_threshold;
        o_cls.hall_on[1]  = i_hall_b < i_threshold;
        o_cls.hall_on[2]  = i_hall_c < i_threshold;
        o_cls.hall_off[0] = i_hall_a > i_threshold;
        o_cls.hall_off[1] = i_hall_b > i_threshold;
        o_cls.hall_off[2] = i_hall_c > i_threshold;
    end

endmodule

/* rtl/core/hss_back.sv */
// back part: sector tracking, position count, commutation state and gate pattern
module hss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hss_pkg::t_cfg      i_cfg,
    input  hss_pkg::t_cls      i_cls,
    input  hss_pkg::t_back_stat i_stat,
    output hss_pkg::t_back_ctl o_ctl,
    output hss_pkg::t_res      o_res
);
    import hss_pkg::*;

    logic [2:0]  r_sector;
    logic [2:0]  r_step;
    logic [13:0] r_pos;
    logic        r_chop;
    logic        r_armed;
    logic        r_running;
    logic        r_pending;

    logic [2:0]  n_sector;
    logic [2:0]  n_step;
    logic [13:0] n_pos;
    logic        n_chop;
    logic        n_armed;
    logic        n_running;
    logic        n_pending;

    logic        fire;
    logic        hall_driven;
    logic        hall_only;
    logic        fwd;
    logic        rev;
    logic signed [5:0] adv;
    logic signed [5:0] adv_m1;
    logic signed [5:0] off;

    assign fire           = !i_stat.in_empty && !i_stat.out_full;
    assign o_ctl.in_pop   = fire;
    assign o_ctl.out_push = fire;
    assign hall_driven    = (i_cfg.mode != MODE_TIMED);
    assign hall_only      = (i_cfg.mode == MODE_HALL_ONLY);
    assign adv            = $signed({{3{i_cfg.advance[2]}}, i_cfg.advance});
    assign adv_m1         = adv - 6'sd1;
    assign off            = $signed({3'b000, i_cfg.offset});

    always_comb begin
        n_sector  = r_sector;
        n_step    = r_step;
        n_pos     = r_pos;
        n_chop    = r_chop;
        n_armed   = r_armed;
        n_running = r_running;
        n_pending = r_pending;
        fwd       = 1'b0;
        rev       = 1'b0;
        if (fire) begin
            unique case (i_cls.cmd)
                CMD_HALL: begin
                    if (r_running && r_pending) begin
                        if (r_armed) begin
                            if (hall_driven) begin
                                n_step = wrap6($signed({3'b000, r_sector}) + off + adv_m1);
                            end else begin
                                n_step = wrap6($signed({3'b000, r_step}) + adv_m1);
                            end
                            if (!hall_only) begin
                                n_armed = 1'b0;
                            end
                        end
                        if (i_cls.hall_on[0]) begin
                            if (i_cls.hall_on[1]) begin
                                n_sector = 3'd2;
                            end else if (i_cls.hall_on[2]) begin
                                n_sector = 3'd6;
                            end else begin
                                n_sector = 3'd1;
                            end
                        end else if (i_cls.hall_on[1]) begin
                            n_sector = i_cls.hall_on[2] ? 3'd4 : 3'd3;
                        end else if (i_cls.hall_on[2]) begin
                            n_sector = 3'd5;
                        end
                        if (hall_driven) begin
                            n_step = wrap6($signed({3'b000, n_sector}) + off);
                        end
                        n_pending = 1'b0;
                    end else if (r_running) begin
                        unique case (r_sector)
                            3'd1: begin fwd = i_cls.hall_on[1];  rev = i_cls.hall_on[2];  end
                            3'd2: begin fwd = i_cls.hall_off[0]; rev = i_cls.hall_off[1]; end
                            3'd3: begin fwd = i_cls.hall_on[2];  rev = i_cls.hall_on[0];  end
                            3'd4: begin fwd = i_cls.hall_off[1]; rev = i_cls.hall_off[2]; end
                            3'd5: begin fwd = i_cls.hall_on[0];  rev = i_cls.hall_on[1];  end
                            default: begin fwd = i_cls.hall_off[2]; rev = i_cls.hall_off[0]; end
                        endcase
                        if (fwd && !rev) begin
                            n_sector = (r_sector == 3'd6) ? 3'd1 : r_sector + 3'd1;
                            n_pos    = (r_pos >= POS_LIMIT) ? 14'd0 : r_pos + 14'd1;
                        end else if (rev && !fwd) begin
                            n_sector = (r_sector == 3'd1) ? 3'd6 : r_sector - 3'd1;
                            n_pos    = (r_pos == 14'd0) ? 14'd0 : r_pos - 14'd1;
                        end
                        if (hall_driven && r_armed) begin
                            n_step = wrap6($signed({3'b000, n_sector}) + off + adv);
                            if (!hall_only) begin
                                n_armed = 1'b0;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (!i_cls.run) begin
                        n_running = 1'b0;
                    end else begin
                        if (!r_running) begin
                            n_running = 1'b1;
                            n_pending = 1'b1;
                        end
                        if (!hall_only) begin
                            if (hall_driven) begin
                                n_step = wrap6($signed({3'b000, r_sector}) + off + adv);
                            end else begin
                                n_step = wrap6($signed({3'b000, r_step}) + adv);
                            end
                            n_armed = 1'b0;
                        end
                    end
                end
                CMD_CHOP_SHORT: n_chop = 1'b1;
                CMD_CHOP_POWER: n_chop = 1'b0;
            endcase
        end
    end

    always_comb begin
        if (!n_running) begin
            o_res.gate_pattern = ALL_OFF;
        end else if (n_chop) begin
            o_res.gate_pattern = shorted_pattern(n_step);
        end else begin
            o_res.gate_pattern = powered_pattern(n_step);
        end
        o_res.drive_step     = n_step;
        o_res.sector         = n_sector;
        o_res.position_count = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector  <= 3'd1;
            r_step    <= 3'd0;
            r_pos     <= 14'd0;
            r_chop    <= 1'b0;
            r_armed   <= 1'b1;
            r_running <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_sector  <= n_sector;
            r_step    <= n_step;
            r_pos     <= n_pos;
            r_chop    <= n_chop;
            r_armed   <= n_armed;
            r_running <= n_running;
            r_pending <= n_pending;
        end
    end

`ifndef ASSERT_OFF
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sector != 3'd0 && r_sector != 3'd7)
        else $error("sector left 1..6");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("position above limit");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 3'd7)
        else $error("step out of range");

    a_stopped_hall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cls.cmd == CMD_HALL && !r_running)
        |=> ($stable(r_sector) && $stable(r_pos) && $stable(r_step)))
        else $error("hall item changed state while stopped");

    a_chop_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cls.cmd == CMD_CHOP_SHORT) |=> r_chop)
        else $error("chop start item did not set the shorted flag");
`endif

endmodule
